// ===== hdl/mck_pkg.sv =====
// Shared types and constants for the Morse code keyer.
// Holds the command format passed from front to back and the symbol table.
// No dependencies.
package mck_pkg;

   localparam int unsigned PAT_W       = 5;   // widest pattern in the table
   localparam int unsigned TLEN_W      = 3;   // element count as stored in the table
   localparam int unsigned CFG_W       = 16;
   localparam int unsigned CFG_IDX_W   = 3;
   localparam int unsigned QUEUE_DEPTH = 4;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] REG_DIT      = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_DAH      = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_SYM_GAP  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_END_TONE = 3'd5;

   localparam logic [CFG_W-1:0] RST_DIT      = 16'd60;
   localparam logic [CFG_W-1:0] RST_DAH      = 16'd180;
   localparam logic [CFG_W-1:0] RST_SYM_GAP  = 16'd120;
   localparam logic [CFG_W-1:0] RST_CHAR_GAP = 16'd300;
   localparam logic [CFG_W-1:0] RST_WORD_GAP = 16'd480;
   localparam logic [CFG_W-1:0] RST_END_TONE = 16'd1000;

   // request actions
   localparam logic [1:0] ACT_CHAR = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_END  = 2'd2;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_Z     = 8'h7A;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [5:0] DIGIT_BASE = 6'd26;

   typedef enum logic [2:0] {
      CMD_NOP,    // undefined action, never accepted
      CMD_TICK,
      CMD_CHAR,   // known character, pattern attached
      CMD_WORD,   // space
      CMD_END,
      CMD_DROP    // unknown character, taken when idle but plays nothing
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [PAT_W-1:0]  pattern;
      logic [TLEN_W-1:0] count;
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TONE,
      PH_SYMGAP,
      PH_CHARGAP,
      PH_WORDGAP,
      PH_ENDTONE
   } phase_type;

   typedef struct packed {
      logic buzzer_on;
      logic busy_res;
      logic accepted;
   } result_type;

   // a..z then 0..9; bit 0 of the pattern plays first, 1 = dah
   localparam logic [TLEN_W-1:0] SYM_LEN [36] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
   };
   localparam logic [PAT_W-1:0] SYM_BITS [36] = '{
      5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
      5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
      5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
   };

endpackage

// ===== hdl/mck_fifo.sv =====
// Small register-based queue between the keyer's front and back.
// Depends on nothing.
module mck_fifo #(
   parameter int unsigned WIDTH = 14,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             not_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];
   assign do_wr     = wr_en && !full;
   assign do_rd     = rd_en && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== hdl/mck_front.sv =====
// Keyer front: takes request transactions, classifies them into commands
// and queues them. Depends on mck_pkg and mck_fifo.
module mck_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [1:0]      action,
   input  logic [7:0]      char_code,
   output logic            cmd_valid,
   output mck_pkg::cmd_type cmd,
   input  logic            cmd_pop
);
   import mck_pkg::*;

   cmd_type    dec;
   logic       q_full;
   logic [5:0] idx;
   logic [7:0] rel;

   always_comb begin
      dec = '{kind: CMD_NOP, pattern: '0, count: '0};
      idx = '0;
      rel = '0;
      case (action)
         ACT_TICK: dec.kind = CMD_TICK;
         ACT_END:  dec.kind = CMD_END;
         ACT_CHAR: begin
            if (char_code == CH_SPACE) begin
               dec.kind = CMD_WORD;
            end else if (char_code inside {[CH_A:CH_Z]}) begin
               rel         = char_code - CH_A;
               idx         = rel[5:0];
               dec.kind    = CMD_CHAR;
               dec.pattern = SYM_BITS[idx];
               dec.count   = SYM_LEN[idx];
            end else if (char_code inside {[CH_0:CH_9]}) begin
               rel         = char_code - CH_0;
               idx         = rel[5:0] + DIGIT_BASE;
               dec.kind    = CMD_CHAR;
               dec.pattern = SYM_BITS[idx];
               dec.count   = SYM_LEN[idx];
            end else begin
               dec.kind = CMD_DROP;
            end
         end
         default: dec.kind = CMD_NOP;
      endcase
   end

   assign req_tready = !q_full;

   mck_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (req_tvalid),
      .wr_data   (dec),
      .full      (q_full),
      .rd_en     (cmd_pop),
      .rd_data   (cmd),
      .not_empty (cmd_valid)
   );

endmodule

// ===== hdl/mck_back.sv =====
// Keyer back: timing sequencer, configuration registers and result register.
// Depends on mck_pkg.
module mck_back #(
   parameter int unsigned MAX_ELEMENTS = 5,
   parameter int unsigned TIMER_WIDTH  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  mck_pkg::cmd_type                cmd,
   output logic                            cmd_pop,
   input  logic                            csr_wr_en,
   input  logic [mck_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [mck_pkg::CFG_W-1:0]       csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mck_pkg::result_type             rsp_result
);
   import mck_pkg::*;

   localparam int unsigned EL_W = $clog2(MAX_ELEMENTS + 1);
   localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

   function automatic logic [TIMER_WIDTH-1:0] sat_len(input logic [CFG_W-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      if (w > TMAX) begin
         sat_len = '1;
      end else begin
         sat_len = w[TIMER_WIDTH-1:0];
      end
   endfunction

   logic [CFG_W-1:0] dit_ff, dah_ff, sym_gap_ff, char_gap_ff, word_gap_ff, end_tone_ff;

   phase_type            phase_ff, phase_in, ph1;
   logic [TIMER_WIDTH-1:0] cnt_ff, cnt_in, cnt1;
   logic [PAT_W-1:0]     pat_ff, pat_in, pat1;
   logic [EL_W-1:0]      left_ff, left_in, left1;
   logic                 pend_ff, pend_in;
   logic                 acc_ff, acc_in, acc_new;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           res_ff, res_now;
   logic                 out_free, emit, settled;
   logic [EL_W-1:0]      clamp_cnt;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cmd_pop  = cmd_valid && !pend_ff && out_free;

   always_comb begin
      if (32'(cmd.count) > MAX_ELEMENTS) begin
         clamp_cnt = EL_W'(MAX_ELEMENTS);
      end else begin
         clamp_cnt = EL_W'(cmd.count);
      end
   end

   // next state: apply the popped command, then one settle step
   always_comb begin
      ph1     = phase_ff;
      cnt1    = cnt_ff;
      pat1    = pat_ff;
      left1   = left_ff;
      acc_new = 1'b0;
      if (cmd_pop) begin
         case (cmd.kind)
            CMD_TICK: begin
               if (phase_ff != PH_IDLE && cnt_ff != '0) begin
                  cnt1 = cnt_ff - 1'b1;
               end
            end
            CMD_CHAR: begin
               if (phase_ff == PH_IDLE) begin
                  acc_new = 1'b1;
                  ph1     = PH_SYMGAP;
                  cnt1    = '0;
                  pat1    = cmd.pattern;
                  left1   = clamp_cnt;
               end
            end
            CMD_WORD: begin
               if (phase_ff == PH_IDLE) begin
                  acc_new = 1'b1;
                  ph1     = PH_WORDGAP;
                  cnt1    = sat_len(word_gap_ff);
               end
            end
            CMD_END: begin
               if (phase_ff == PH_IDLE) begin
                  acc_new = 1'b1;
                  ph1     = PH_ENDTONE;
                  cnt1    = sat_len(end_tone_ff);
               end
            end
            CMD_DROP: acc_new = (phase_ff == PH_IDLE);
            default: ;
         endcase
      end

      phase_in = ph1;
      cnt_in   = cnt1;
      pat_in   = pat1;
      left_in  = left1;
      if (ph1 != PH_IDLE && cnt1 == '0) begin
         case (ph1)
            PH_TONE: begin
               phase_in = PH_SYMGAP;
               cnt_in   = sat_len(sym_gap_ff);
            end
            PH_SYMGAP: begin
               if (left1 != '0) begin
                  phase_in = PH_TONE;
                  cnt_in   = sat_len(pat1[0] ? dah_ff : dit_ff);
                  pat_in   = pat1 >> 1;
                  left_in  = left1 - 1'b1;
               end else begin
                  phase_in = PH_CHARGAP;
                  cnt_in   = sat_len(char_gap_ff);
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      settled      = (phase_in == PH_IDLE) || (cnt_in != '0);
      emit         = (cmd_pop || pend_ff) && settled && out_free;
      pend_in      = (cmd_pop || pend_ff) && !emit;
      acc_in       = cmd_pop ? acc_new : acc_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   // result fields as seen after this cycle's update
   always_comb begin
      res_now.buzzer_on = (phase_in == PH_TONE) || (phase_in == PH_ENDTONE);
      res_now.busy_res  = (phase_in != PH_IDLE);
      res_now.accepted  = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         pat_ff       <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dit_ff       <= RST_DIT;
         dah_ff       <= RST_DAH;
         sym_gap_ff   <= RST_SYM_GAP;
         char_gap_ff  <= RST_CHAR_GAP;
         word_gap_ff  <= RST_WORD_GAP;
         end_tone_ff  <= RST_END_TONE;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         pat_ff       <= pat_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_DIT:      dit_ff      <= csr_wdata;
               REG_DAH:      dah_ff      <= csr_wdata;
               REG_SYM_GAP:  sym_gap_ff  <= csr_wdata;
               REG_CHAR_GAP: char_gap_ff <= csr_wdata;
               REG_WORD_GAP: word_gap_ff <= csr_wdata;
               REG_END_TONE: end_tone_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         res_ff <= res_now;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = res_ff;

endmodule

// ===== hdl/morse_code_keyer.sv =====
// Morse code keyer top level: front classifier, command queue, back sequencer.
// Depends on mck_pkg, mck_front, mck_back.
//
// Usage:
//  - req_ channel: one transaction per message character, time tick or
//    end-of-message mark. While idle, characters a-z, 0-9 play their Morse
//    pattern, space plays a word gap, anything else is taken and dropped.
//  - rsp_ channel: exactly one transaction per request, in order, giving
//    buzzer state, busy state and whether the request was taken.
//  - csr_ port: write-only timing registers (dit, dah, symbol gap, char gap,
//    word gap, end tone), written only while the keyer is idle (user's rule;
//    the keyer itself does not enforce it). A response is registered at the
//    edge that pops its request from the 4-entry queue, unless that step
//    lands on zero-length phases; then it waits while the single settle step
//    per cycle skips them. Throughput is one transaction per cycle while
//    neither rsp_tready nor a pending settle stalls the keyer.
//  - Reset (synchronous): queue emptied, keyer idle, registers at defaults.
//  - A stalled rsp_tready holds the response; the queue keeps absorbing
//    requests until full, then req_tready drops.
module morse_code_keyer #(
   parameter int unsigned MAX_ELEMENTS = 5,
   parameter int unsigned TIMER_WIDTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: [1:0] action, [9:2] char_code, [15:10] zero
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,
   // rsp_tdata: [0] buzzer_on, [1] busy_res, [2] accepted, [7:3] zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [mck_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [mck_pkg::CFG_W-1:0]     csr_wdata
);
   import mck_pkg::*;

   cmd_type    cmd;
   logic       cmd_valid;
   logic       cmd_pop;
   result_type res;

   mck_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tdata[1:0]),
      .char_code  (req_tdata[9:2]),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   mck_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .TIMER_WIDTH  (TIMER_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (res)
   );

   // upper request bits [15:10] are padding and ignored
   assign rsp_tdata = {5'b0, res.accepted, res.busy_res, res.buzzer_on};

endmodule
